// File: sv/hbt_pkg.sv
`default_nettype none
package hbt_pkg;
  localparam logic [63:0] MIX_MULT = 64'h0045_d9f3_b45d_9f3b;
  localparam int MIX_SHIFT = 32;
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] white_occupancy;
    logic [63:0] black_occupancy;
    logic        white_to_move;
    logic [63:0] best_move;
    logic signed [15:0] score_in;
    logic [1:0]  bound_kind;
    logic [7:0]  depth_in;
    logic [15:0] age_in;
  } in_beat_t;

  typedef struct packed {
    logic        hit;
    logic        written;
    logic [63:0] move_out;
    logic signed [15:0] score_out;
    logic [1:0]  bound_out;
    logic [7:0]  depth_out;
    logic [15:0] age_out;
  } out_beat_t;
endpackage
`default_nettype wire

// File: sv/hashed_bucket_table_depth_replace.sv
`default_nettype none
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | hbt_pkg::in_beat_t
// out     | output    | out_valid/out_ready | hbt_pkg::out_beat_t
// One item at a time. Per occupancy word the hash runs two rounds, each forming
// three 32x32 partial products and then adding them, followed by one fold.
// Each slot probe has two steps: the address, then the registered read and compare.
// Clear and reset sweep the keys of all 2^INDEX_BITS + BUCKET_WAYS slots, in_ready low.
// The result waits in an output register; out_ready low holds it and the input.
module hashed_bucket_table_depth_replace #(
  parameter int INDEX_BITS  = 10,
  parameter int BUCKET_WAYS = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  hbt_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output hbt_pkg::out_beat_t  out_data
);
  import hbt_pkg::*;

  localparam int SLOTS = (1 << INDEX_BITS) + BUCKET_WAYS;
  localparam int AW    = $clog2(SLOTS);
  localparam int WW    = $clog2(BUCKET_WAYS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL0  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_FOLD  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_EVAL  = 4'd5;
  localparam logic [3:0] S_WRITE = 4'd6;
  localparam logic [3:0] S_CLEAR = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [63:0] key_mem [SLOTS];
  logic [63:0] move_mem [SLOTS];
  logic [41:0] info_mem [SLOTS];

  logic [3:0]  state_r;
  in_beat_t    item_r;
  logic [63:0] x_r, acc_r, hw_r, hash_r;
  logic [1:0]  round_r;
  logic        word_r;
  logic [AW-1:0] addr_r, pick_r;
  logic [WW-1:0] way_r;
  logic [8:0]  lowest_r;
  logic        drop_r;
  out_beat_t   out_r;
  logic        out_valid_r;

  logic [63:0] rd_key, rd_move;
  logic [41:0] rd_info;
  logic [AW-1:0] rd_addr;
  logic        we;
  logic [AW-1:0] wa;
  logic [63:0] wkey;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // mixer operand and partial products (low 64 bits of y*MULT)
  logic [63:0] y;
  logic [63:0] pp_lo, pp_cross;
  assign y        = (x_r >> MIX_SHIFT) ^ x_r;
  assign pp_lo    = y[31:0] * MIX_MULT[31:0];
  assign pp_cross = {(y[31:0] * MIX_MULT[63:32]) + (y[63:32] * MIX_MULT[31:0]), 32'd0};

  logic [AW-1:0] base;
  assign base = AW'(hash_r[63 -: INDEX_BITS]);

  // present the probe address to the memory in the same cycle it is chosen
  assign rd_addr = (state_r == S_SCAN) ? base + AW'(way_r) : addr_r;

  // memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wa] <= wkey;
      if (state_r == S_WRITE) begin
        move_mem[wa] <= item_r.best_move;
        info_mem[wa] <= {item_r.age_in, item_r.depth_in, item_r.bound_kind, item_r.score_in};
      end
    end
    rd_key  <= key_mem[rd_addr];
    rd_move <= move_mem[rd_addr];
    rd_info <= info_mem[rd_addr];
  end

  always_comb begin
    we = 1'b0; wa = addr_r; wkey = 64'd0;
    if (state_r == S_CLEAR) we = 1'b1;
    if (state_r == S_WRITE) begin
      we = 1'b1; wa = pick_r; wkey = hash_r;
    end
  end

  logic [7:0]  sd;
  logic [15:0] sa;
  logic [16:0] sa1;
  assign sd  = rd_info[25:18];
  assign sa  = rd_info[41:26];
  assign sa1 = {1'b0, sa} + 17'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r <= '0;
      out_valid_r <= 1'b0;
      drop_r <= 1'b1;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          item_r <= in_data;
          out_r <= '0;
          if (in_data.operation == OP_CLEAR) begin
            addr_r <= '0; state_r <= S_CLEAR;
          end else if (in_data.operation == OP_LOOKUP || in_data.operation == OP_STORE) begin
            x_r <= in_data.white_occupancy; word_r <= 1'b0; round_r <= '0;
            state_r <= S_MUL0;
          end else state_r <= S_OUT;
        end
        S_MUL0: begin
          acc_r <= pp_lo; x_r <= pp_cross; state_r <= S_MUL1;
        end
        S_MUL1: begin
          // x_r held cross term; rebuild from acc
          x_r <= acc_r + x_r;
          if (round_r == 2'd1) state_r <= S_FOLD;
          else begin round_r <= round_r + 2'd1; state_r <= S_MUL0; end
        end
        S_FOLD: begin
          if (!word_r) begin
            hw_r <= (x_r >> MIX_SHIFT) ^ x_r;
            x_r <= item_r.black_occupancy; word_r <= 1'b1; round_r <= '0;
            state_r <= S_MUL0;
          end else begin
            hash_r <= item_r.white_to_move ? (hw_r ^ ((x_r >> MIX_SHIFT) ^ x_r))
                                           : ~(hw_r ^ ((x_r >> MIX_SHIFT) ^ x_r));
            way_r <= '0; drop_r <= 1'b0; lowest_r <= 9'h1ff;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          addr_r <= rd_addr; state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (item_r.operation == OP_LOOKUP) begin
            if (hash_r != 64'd0 && rd_key == hash_r) begin
              out_r.hit <= 1'b1; out_r.move_out <= rd_move;
              out_r.score_out <= rd_info[15:0]; out_r.bound_out <= rd_info[17:16];
              out_r.depth_out <= sd; out_r.age_out <= sa;
              state_r <= S_OUT;
            end else if (way_r == WW'(BUCKET_WAYS - 1)) state_r <= S_OUT;
            else begin way_r <= way_r + 1'b1; state_r <= S_SCAN; end
          end else begin
            if (rd_key == 64'd0 || sa1 < {1'b0, item_r.age_in} || rd_key == hash_r) begin
              pick_r <= addr_r;
              if (rd_key != 64'd0 && !(sa1 < {1'b0, item_r.age_in}) && sd > item_r.depth_in) begin
                drop_r <= 1'b1; state_r <= S_OUT;
              end else state_r <= S_WRITE;
            end else begin
              if ({1'b0, sd} < lowest_r) begin lowest_r <= {1'b0, sd}; pick_r <= addr_r; end
              if (way_r == WW'(BUCKET_WAYS - 1)) state_r <= S_WRITE;
              else begin way_r <= way_r + 1'b1; state_r <= S_SCAN; end
            end
          end
        end
        S_WRITE: begin
          out_r.written <= 1'b1; state_r <= S_OUT;
        end
        S_CLEAR: begin
          if (addr_r == AW'(SLOTS - 1)) begin
            addr_r <= '0;
            if (item_r.operation == OP_CLEAR && !drop_r) state_r <= S_OUT;
            else state_r <= S_IDLE;
          end else addr_r <= addr_r + 1'b1;
        end
        S_OUT: begin
          out_valid_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_IDLE && !(in_valid && in_ready)) drop_r <= 1'b1;
      if (state_r == S_IDLE && in_valid && in_ready) drop_r <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: test/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hbt_pkg::*;

  localparam int IDX_BITS   = 10;
  localparam int WAYS       = 4;
  localparam int SLOTS      = (1 << IDX_BITS) + WAYS;
  localparam int RAND_ITEMS = 600;
  localparam int POOL_SIZE  = 12;
  localparam int POOL_BASE  = 500;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    in_beat_t  beat;
    bit        fixed;
    out_beat_t want;
  } table_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  // shadow copy of the slot memory
  logic [63:0] shadow_key  [SLOTS];
  logic [63:0] shadow_move [SLOTS];
  logic [41:0] shadow_info [SLOTS];

  // positions that all land in one small group of windows
  logic [63:0] pool_white [POOL_SIZE];
  logic [63:0] pool_black [POOL_SIZE];
  logic        pool_stm   [POOL_SIZE];

  out_beat_t   expected_q[$];
  int          mismatches = 0;
  bit          calm = 1'b0;

  hashed_bucket_table_depth_replace #(.INDEX_BITS(IDX_BITS), .BUCKET_WAYS(WAYS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] mix(logic [63:0] x);
    logic [63:0] m;
    m = x;
    m = ((m >> MIX_SHIFT) ^ m) * MIX_MULT;
    m = ((m >> MIX_SHIFT) ^ m) * MIX_MULT;
    return (m >> MIX_SHIFT) ^ m;
  endfunction

  function automatic logic [63:0] board_hash(logic [63:0] w, logic [63:0] b, logic stm);
    logic [63:0] h;
    h = mix(w) ^ mix(b);
    return stm ? h : ~h;
  endfunction

  // predict one beat and update the shadow table
  function automatic out_beat_t probe_table(in_beat_t b);
    out_beat_t   r;
    logic [63:0] h;
    int          base, pick, lowest, d;
    bit          drop;
    r = '0;
    h = board_hash(b.white_occupancy, b.black_occupancy, b.white_to_move);
    base = int'(h[63 -: IDX_BITS]);
    if (b.operation == OP_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) begin
        shadow_key[i] = '0;
        shadow_move[i] = '0;
        shadow_info[i] = '0;
      end
    end else if (b.operation == OP_LOOKUP) begin
      if (h != '0) begin
        for (int i = base; i < base + WAYS; i++) begin
          if (shadow_key[i] == h) begin
            r.hit = 1'b1;
            r.move_out = shadow_move[i];
            r.score_out = shadow_info[i][15:0];
            r.bound_out = shadow_info[i][17:16];
            r.depth_out = shadow_info[i][25:18];
            r.age_out = shadow_info[i][41:26];
            break;
          end
        end
      end
    end else if (b.operation == OP_STORE) begin
      lowest = 1000;
      pick = base;
      drop = 1'b0;
      for (int i = base; i < base + WAYS; i++) begin
        if (shadow_key[i] == '0) begin
          pick = i;
          break;
        end
        if (int'(shadow_info[i][41:26]) + 1 < int'(b.age_in)) begin
          pick = i;
          break;
        end
        d = int'(shadow_info[i][25:18]);
        if (shadow_key[i] == h) begin
          drop = d > int'(b.depth_in);
          pick = i;
          break;
        end
        if (d < lowest) begin
          lowest = d;
          pick = i;
        end
      end
      if (!drop) begin
        shadow_key[pick] = h;
        shadow_move[pick] = b.best_move;
        shadow_info[pick] = {b.age_in, b.depth_in, b.bound_kind, b.score_in};
        r.written = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic in_beat_t make_beat(logic [1:0] op, int p, logic [7:0] depth,
                                         logic [15:0] age);
    in_beat_t b;
    b.operation = op;
    b.white_occupancy = pool_white[p];
    b.black_occupancy = pool_black[p];
    b.white_to_move = pool_stm[p];
    b.best_move = rand64();
    b.score_in = 16'($urandom);
    b.bound_kind = 2'($urandom);
    b.depth_in = depth;
    b.age_in = age;
    return b;
  endfunction

  // drive one beat and hold it until accepted, then record its expectation
  task automatic send_beat(in_beat_t b, bit fixed, out_beat_t want);
    out_beat_t p;
    if (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    p = probe_table(b);
    expected_q.push_back(fixed ? want : p);
  endtask

  // result side: random back-pressure and field checks
  initial begin
    out_beat_t e;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          e = expected_q.pop_front();
          if (out_data.hit !== e.hit || out_data.written !== e.written ||
              out_data.move_out !== e.move_out || out_data.score_out !== e.score_out ||
              out_data.bound_out !== e.bound_out || out_data.depth_out !== e.depth_out ||
              out_data.age_out !== e.age_out) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data);
          end
        end
      end
      out_ready <= rst_n && (calm || $urandom_range(99) >= 21);
    end
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    table_row_t  rows[$];
    table_row_t  row;
    in_beat_t    b;
    out_beat_t   none;
    logic [63:0] h;
    logic [15:0] gen;
    int          found, roll, p, waited;
    logic [7:0]  dep;
    logic [15:0] ag;

    none = '0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_key[i] = '0;
      shadow_move[i] = '0;
      shadow_info[i] = '0;
    end

    // search for positions crowding the same windows
    found = 0;
    while (found < POOL_SIZE) begin
      pool_white[found] = rand64();
      pool_black[found] = rand64();
      pool_stm[found] = 1'($urandom);
      h = board_hash(pool_white[found], pool_black[found], pool_stm[found]);
      if (int'(h[63 -: IDX_BITS]) >= POOL_BASE && int'(h[63 -: IDX_BITS]) < POOL_BASE + 3)
        found++;
    end

    // directed rows
    row.fixed = 1'b1; row.want = none;
    row.beat = make_beat(OP_LOOKUP, 0, 8'd0, 16'd0); rows.push_back(row);
    row.beat = make_beat(OP_UNUSED, 1, 8'd255, 16'hFFFF); rows.push_back(row);
    row.want.written = 1'b1;
    row.beat = make_beat(OP_STORE, 0, 8'd0, 16'd0);
    row.beat.best_move = '0; row.beat.score_in = -16'sd32768; row.beat.bound_kind = 2'd0;
    rows.push_back(row);
    row.beat = make_beat(OP_STORE, 1, 8'd255, 16'hFFFF);
    row.beat.best_move = '1; row.beat.score_in = 16'sd32767; row.beat.bound_kind = 2'd3;
    rows.push_back(row);
    row.fixed = 1'b0;
    row.beat = make_beat(OP_LOOKUP, 0, 8'd0, 16'd0); rows.push_back(row);
    row.beat = make_beat(OP_LOOKUP, 1, 8'd0, 16'd0); rows.push_back(row);
    row.beat = make_beat(OP_STORE, 0, 8'd0, 16'd1); rows.push_back(row);
    row.beat = make_beat(OP_STORE, 1, 8'd10, 16'hFFFF); rows.push_back(row);
    for (int i = 2; i < 8; i++) begin
      row.beat = make_beat(OP_STORE, i, 8'(i * 3), 16'hFFFF); rows.push_back(row);
    end
    for (int i = 0; i < 8; i++) begin
      row.beat = make_beat(OP_LOOKUP, i, 8'd0, 16'd0); rows.push_back(row);
    end
    row.fixed = 1'b1; row.want = none;
    row.beat = make_beat(OP_CLEAR, 2, 8'd0, 16'd0); rows.push_back(row);
    row.beat = make_beat(OP_LOOKUP, 1, 8'd0, 16'd0); rows.push_back(row);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_beat(rows[i].beat, rows[i].fixed, rows[i].want);

    // random traffic, mostly on the crowded windows
    gen = 16'd2;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= 250 && n < 370);
      if ($urandom_range(99) < 4) gen = gen + 16'($urandom_range(3, 1));
      roll = $urandom_range(99);
      p = $urandom_range(POOL_SIZE - 1);
      dep = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
      ag = ($urandom_range(19) == 0) ? 16'($urandom) : gen - 16'($urandom_range(1));
      if (roll < 48) b = make_beat(OP_STORE, p, dep, ag);
      else if (roll < 88) b = make_beat(OP_LOOKUP, p, dep, ag);
      else if (roll < 91) b = make_beat(OP_CLEAR, p, dep, ag);
      else if (roll < 93) b = make_beat(OP_UNUSED, p, dep, ag);
      else begin
        b = make_beat(2'($urandom_range(1)), p, dep, ag);
        b.white_occupancy = rand64();
        b.black_occupancy = rand64();
        b.white_to_move = 1'($urandom);
      end
      send_beat(b, 1'b0, none);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // drain
    waited = 0;
    while (expected_q.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: hashed_bucket_table_depth_replace.f
sv/hbt_pkg.sv
sv/hashed_bucket_table_depth_replace.sv
test/testbench.sv
